[hdl/lkf_pkg.sv]
// ----------------------------------------------------------------------------
// lkf_pkg
// Shared constants, codes and control types of the optical flow block.
// ----------------------------------------------------------------------------
package lkf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 10;
    localparam int CFG_W       = 11;
    localparam int PIX_W       = 8;
    localparam int FLOW_W      = 16;
    localparam int FRAC_BITS   = 8;
    localparam int BORDER      = 3;
    localparam int STORE_LINES = 2 * BORDER + 1;
    localparam int LINE_W      = 3;
    localparam int ADDR_W      = LINE_W + COL_W;
    localparam int RAM_DEPTH   = STORE_LINES * MAX_WIDTH;
    localparam int SUM_W       = 23;
    localparam int PROD_W      = 2 * SUM_W;
    localparam int SOLVE_W     = PROD_W + 1;
    localparam int QUO_W       = 17;
    localparam int DIV_W       = 64;
    localparam int WIN_LAST    = 4;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // window taps around one gradient position
    localparam logic [2:0] TAP_RIGHT  = 3'd0;
    localparam logic [2:0] TAP_LEFT   = 3'd1;
    localparam logic [2:0] TAP_DOWN   = 3'd2;
    localparam logic [2:0] TAP_UP     = 3'd3;
    localparam logic [2:0] TAP_CENTER = 3'd4;

    // products of the 2x2 solve, in issue order
    localparam logic [2:0] MUL_SXX_SYY = 3'd0;
    localparam logic [2:0] MUL_SXY_SXY = 3'd1;
    localparam logic [2:0] MUL_SXY_SYT = 3'd2;
    localparam logic [2:0] MUL_SYY_SXT = 3'd3;
    localparam logic [2:0] MUL_SXY_SXT = 3'd4;
    localparam logic [2:0] MUL_SXX_SYT = 3'd5;

    typedef struct packed {
        logic       accept;
        logic       rd;
        logic [2:0] tap;
        logic [2:0] win_row;
        logic [2:0] win_col;
        logic       acc;
        logic       mul;
        logic [2:0] mul_op;
        logic       div_start;
        logic       div_sel;
        logic       div_step;
        logic       div_fin;
        logic       load_out;
    } lkf_cmd_t;

    typedef struct packed {
        logic has_result;
        logic out_free;
    } lkf_sts_t;

endpackage

[hdl/lucas_kanade_flow.sv]
// ----------------------------------------------------------------------------
// lucas_kanade_flow
// 5x5 Lucas-Kanade optical flow over a raster stream of pixel pairs.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one beat per co-located pixel pair of the earlier and later
//   frame, raster order; s_frame_start marks pixel (0,0) of a frame.
//   m_ channel: one beat per interior window centre, flow in signed q8.8,
//   saturated, with solvable, centre column/row and last_of_frame.
//   cfg port: frame_width (index 0) and frame_height (index 1), written
//   while the block is idle.
// timing:
//   a border pixel is only written to the line stores. an interior pixel runs
//   a window sweep (25 positions, 5 reads each through the single read port
//   of the line stores), then the products on the shared solve multiplier and
//   two 17-step divisions; its beat is then loaded into the output register.
//   the next pixel is taken while a finished beat still waits on m_ready;
//   a stalled receiver holds the block only when a second result is ready.
// reset:
//   counters go to (0,0), sizes to 640x480, no beat pending. the line
//   stores are not cleared; every entry is written before it is read.
// ----------------------------------------------------------------------------
module lucas_kanade_flow
    import lkf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIX_W-1:0]         s_prev_pixel,
    input  logic [PIX_W-1:0]         s_next_pixel,
    input  logic                     s_frame_start,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [FLOW_W-1:0] m_flow_u,
    output logic signed [FLOW_W-1:0] m_flow_v,
    output logic                     m_solvable,
    output logic [COL_W-1:0]         m_center_col,
    output logic [ROW_W-1:0]         m_center_row,
    output logic                     m_last_of_frame
);

    lkf_cmd_t cmd;
    lkf_sts_t sts;

    lkf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lkf_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_prev_pixel    (s_prev_pixel),
        .s_next_pixel    (s_next_pixel),
        .s_frame_start   (s_frame_start),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_flow_u        (m_flow_u),
        .m_flow_v        (m_flow_v),
        .m_solvable      (m_solvable),
        .m_center_col    (m_center_col),
        .m_center_row    (m_center_row),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

[hdl/lkf_ram.sv]
// ----------------------------------------------------------------------------
// lkf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lkf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/lkf_ctrl.sv]
// ----------------------------------------------------------------------------
// lkf_ctrl
// Sequencer: window sweep, solve products, two divisions, result hand-off.
// ----------------------------------------------------------------------------
module lkf_ctrl
    import lkf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lkf_sts_t sts,
    output lkf_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WIN   = 3'd1;
    localparam logic [2:0] ST_SOLVE = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [2:0] PH_ACC   = 3'd6;
    localparam logic [4:0] SOLVE_END = 5'd6;
    localparam logic [4:0] DIV_FIN   = 5'd18;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] wr_reg, wr_next;
    logic [2:0] wc_reg, wc_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            wr_reg    <= '0;
            wc_reg    <= '0;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            wr_reg    <= wr_next;
            wc_reg    <= wc_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        wr_next    = wr_reg;
        wc_next    = wc_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.win_row = wr_reg;
        cmd.win_col = wc_reg;
        cmd.tap     = phase_reg;
        cmd.mul_op  = cnt_reg[2:0];
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid && sts.has_result) begin
                    state_next = ST_WIN;
                    phase_next = '0;
                    wr_next    = '0;
                    wc_next    = '0;
                end
            end
            ST_WIN: begin
                cmd.rd  = (phase_reg <= TAP_CENTER);
                cmd.acc = (phase_reg == PH_ACC);
                if (phase_reg == PH_ACC) begin
                    phase_next = '0;
                    if (wc_reg == 3'(WIN_LAST)) begin
                        wc_next = '0;
                        if (wr_reg == 3'(WIN_LAST)) begin
                            state_next = ST_SOLVE;
                            cnt_next   = '0;
                        end else begin
                            wr_next = wr_reg + 3'd1;
                        end
                    end else begin
                        wc_next = wc_reg + 3'd1;
                    end
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_SOLVE: begin
                // last count only drains the product pipeline
                cmd.mul = (cnt_reg < SOLVE_END);
                if (cnt_reg == SOLVE_END) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                    sel_next   = 1'b0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DIV: begin
                cmd.div_start = (cnt_reg == 5'd0);
                cmd.div_fin   = (cnt_reg == DIV_FIN);
                cmd.div_step  = (cnt_reg != 5'd0) && (cnt_reg != DIV_FIN);
                if (cnt_reg == DIV_FIN) begin
                    cnt_next = '0;
                    sel_next = 1'b1;
                    if (sel_reg) begin
                        state_next = ST_OUT;
                    end
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_OUT: begin
                cmd.load_out = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_win_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && sts.has_result) |=> (state_reg == ST_WIN))
        else $error("interior pixel did not start a window sweep");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a waiting beat");

    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WIN && phase_reg == PH_ACC && wr_reg == 3'(WIN_LAST)
         && wc_reg == 3'(WIN_LAST)) |=> (state_reg == ST_SOLVE))
        else $error("window sweep did not hand over to the solve");

endmodule

[hdl/lkf_dp.sv]
// ----------------------------------------------------------------------------
// lkf_dp
// Datapath: raster counters, line stores, window sums, solve and divider.
// ----------------------------------------------------------------------------
module lkf_dp
    import lkf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic [PIX_W-1:0]         s_prev_pixel,
    input  logic [PIX_W-1:0]         s_next_pixel,
    input  logic                     s_frame_start,
    input  lkf_cmd_t                 cmd,
    output lkf_sts_t                 sts,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [FLOW_W-1:0] m_flow_u,
    output logic signed [FLOW_W-1:0] m_flow_v,
    output logic                     m_solvable,
    output logic [COL_W-1:0]         m_center_col,
    output logic [ROW_W-1:0]         m_center_row,
    output logic                     m_last_of_frame
);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [CFG_W-1:0] w_eff, h_eff;
    always_comb begin
        w_eff = width_reg;
        if (width_reg > CFG_W'(MAX_WIDTH)) w_eff = CFG_W'(MAX_WIDTH);
        if (width_reg == '0) w_eff = CFG_W'(1);
        h_eff = height_reg;
        if (height_reg > CFG_W'(1024)) h_eff = CFG_W'(1024);
        if (height_reg == '0) h_eff = CFG_W'(1);
    end

    // ---------------- raster position ----------------
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [LINE_W-1:0] ymod_reg, ymod_next;
    logic [COL_W-1:0]  x_cur;
    logic [ROW_W-1:0]  y_cur;
    logic [LINE_W-1:0] ymod_cur;
    logic [CFG_W-1:0]  col_a, row_a, col_inc, row_inc;
    logic [LINE_W-1:0] ymod_a;
    logic              last_cur;

    function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] l);
        line_inc = (l == LINE_W'(STORE_LINES - 1)) ? '0 : l + LINE_W'(1);
    endfunction

    always_comb begin
        col_a  = s_frame_start ? '0 : {1'b0, col_reg};
        row_a  = s_frame_start ? '0 : {1'b0, row_reg};
        ymod_a = s_frame_start ? '0 : ymod_reg;
        // column left past the line end by a size change
        if (col_a >= w_eff) begin
            col_a  = '0;
            row_a  = row_a + CFG_W'(1);
            ymod_a = line_inc(ymod_a);
        end
        if (row_a >= h_eff) begin
            row_a  = '0;
            ymod_a = '0;
        end
        x_cur    = col_a[COL_W-1:0];
        y_cur    = row_a[ROW_W-1:0];
        ymod_cur = ymod_a;
        last_cur = (col_a == w_eff - CFG_W'(1)) && (row_a == h_eff - CFG_W'(1));

        col_inc   = col_a + CFG_W'(1);
        row_inc   = row_a + CFG_W'(1);
        col_next  = col_inc[COL_W-1:0];
        row_next  = y_cur;
        ymod_next = ymod_cur;
        if (col_inc >= w_eff) begin
            col_next  = '0;
            row_next  = row_inc[ROW_W-1:0];
            ymod_next = line_inc(ymod_cur);
            if (row_inc >= h_eff) begin
                row_next  = '0;
                ymod_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            ymod_reg <= '0;
        end else if (cmd.accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ymod_reg <= ymod_next;
        end
    end

    assign sts.has_result = (x_cur >= COL_W'(2 * BORDER)) && (y_cur >= ROW_W'(2 * BORDER));

    // item in progress
    logic [COL_W-1:0]  px_reg;
    logic [ROW_W-1:0]  py_reg;
    logic [LINE_W-1:0] pl_reg;
    logic              plast_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg    <= x_cur;
            py_reg    <= y_cur;
            pl_reg    <= ymod_cur;
            plast_reg <= last_cur;
        end
    end

    // ---------------- line stores ----------------
    logic [ADDR_W-1:0] waddr, raddr;
    logic [PIX_W-1:0]  e_rdata, l_rdata;
    logic [LINE_W:0]   line_sum;
    logic [LINE_W-1:0] rline;
    logic [1:0]        row_adj, col_adj;
    logic [COL_W-1:0]  rcol;

    assign waddr = {ymod_cur, x_cur};

    always_comb begin
        case (cmd.tap)
            TAP_RIGHT: begin row_adj = 2'd1; col_adj = 2'd2; end
            TAP_LEFT:  begin row_adj = 2'd1; col_adj = 2'd0; end
            TAP_DOWN:  begin row_adj = 2'd2; col_adj = 2'd1; end
            TAP_UP:    begin row_adj = 2'd0; col_adj = 2'd1; end
            default:   begin row_adj = 2'd1; col_adj = 2'd1; end
        endcase
        // rows y-6..y taken modulo the store depth, y-6 lands on line y+1
        line_sum = {1'b0, pl_reg} + {1'b0, cmd.win_row} + (LINE_W+1)'(row_adj)
                 + (LINE_W+1)'(1);
        if (line_sum >= (LINE_W+1)'(STORE_LINES)) begin
            line_sum = line_sum - (LINE_W+1)'(STORE_LINES);
        end
        rline = line_sum[LINE_W-1:0];
        rcol  = px_reg + COL_W'(cmd.win_col) + COL_W'(col_adj) - COL_W'(2 * BORDER);
        raddr = {rline, rcol};
    end

    lkf_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_earlier (
        .aclk  (aclk),
        .we    (cmd.accept),
        .waddr (waddr),
        .wdata (s_prev_pixel),
        .raddr (raddr),
        .rdata (e_rdata)
    );

    lkf_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_later (
        .aclk  (aclk),
        .we    (cmd.accept),
        .waddr (waddr),
        .wdata (s_next_pixel),
        .raddr (raddr),
        .rdata (l_rdata)
    );

    // ---------------- tap capture and sums ----------------
    logic             rd_vld_reg;
    logic [2:0]       rd_tap_reg;
    logic [PIX_W-1:0] e_r_reg, e_l_reg, e_d_reg, e_u_reg, e_c_reg, l_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd;
        end
    end

    always_ff @(posedge aclk) begin
        rd_tap_reg <= cmd.tap;
        if (rd_vld_reg) begin
            case (rd_tap_reg)
                TAP_RIGHT: e_r_reg <= e_rdata;
                TAP_LEFT:  e_l_reg <= e_rdata;
                TAP_DOWN:  e_d_reg <= e_rdata;
                TAP_UP:    e_u_reg <= e_rdata;
                default: begin
                    e_c_reg <= e_rdata;
                    l_c_reg <= l_rdata;
                end
            endcase
        end
    end

    logic signed [PIX_W:0]     ix, iy, it;
    logic signed [2*PIX_W+1:0] pxx, pyy, pxy, pxt, pyt;
    logic signed [SUM_W-1:0]   sxx_reg, syy_reg, sxy_reg, sxt_reg, syt_reg;

    assign ix  = $signed({1'b0, e_r_reg}) - $signed({1'b0, e_l_reg});
    assign iy  = $signed({1'b0, e_d_reg}) - $signed({1'b0, e_u_reg});
    assign it  = $signed({1'b0, l_c_reg}) - $signed({1'b0, e_c_reg});
    assign pxx = ix * ix;
    assign pyy = iy * iy;
    assign pxy = ix * iy;
    assign pxt = ix * it;
    assign pyt = iy * it;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
            sxt_reg <= '0;
            syt_reg <= '0;
        end else if (cmd.acc) begin
            sxx_reg <= sxx_reg + SUM_W'(pxx);
            syy_reg <= syy_reg + SUM_W'(pyy);
            sxy_reg <= sxy_reg + SUM_W'(pxy);
            sxt_reg <= sxt_reg + SUM_W'(pxt);
            syt_reg <= syt_reg + SUM_W'(pyt);
        end
    end

    // ---------------- 2x2 solve, one product a cycle ----------------
    logic signed [SUM_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  first_reg;
    logic                      mul_vld_reg;
    logic [2:0]                mul_op_reg;
    logic signed [SOLVE_W-1:0] det_reg, nu_reg, nv_reg, diff;

    always_comb begin
        case (cmd.mul_op)
            MUL_SXX_SYY: begin mul_a = sxx_reg; mul_b = syy_reg; end
            MUL_SXY_SXY: begin mul_a = sxy_reg; mul_b = sxy_reg; end
            MUL_SXY_SYT: begin mul_a = sxy_reg; mul_b = syt_reg; end
            MUL_SYY_SXT: begin mul_a = syy_reg; mul_b = sxt_reg; end
            MUL_SXY_SXT: begin mul_a = sxy_reg; mul_b = sxt_reg; end
            default:     begin mul_a = sxx_reg; mul_b = syt_reg; end
        endcase
    end

    assign diff = SOLVE_W'(first_reg) - SOLVE_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else begin
            mul_vld_reg <= cmd.mul;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= mul_a * mul_b;
        mul_op_reg <= cmd.mul_op;
        if (mul_vld_reg) begin
            case (mul_op_reg)
                MUL_SXY_SXY: det_reg   <= diff;
                MUL_SYY_SXT: nu_reg    <= diff;
                MUL_SXX_SYT: nv_reg    <= diff;
                default:     first_reg <= prod_reg;
            endcase
        end
    end

    // ---------------- restoring divider, one quotient bit a cycle ----------------
    logic signed [SOLVE_W-1:0] num;
    logic [SOLVE_W-1:0]        n_mag, d_mag;
    logic [DIV_W-1:0]          n_sh, d_top;
    logic [DIV_W-1:0]          rem_reg, ds_reg;
    logic [QUO_W-1:0]          q_reg;
    logic                      neg_reg, ovf_reg;
    logic signed [FLOW_W-1:0]  quo_sat, u_reg, v_reg;

    always_comb begin
        num   = cmd.div_sel ? nv_reg : nu_reg;
        n_mag = num[SOLVE_W-1] ? SOLVE_W'(-num) : SOLVE_W'(num);
        d_mag = det_reg[SOLVE_W-1] ? SOLVE_W'(-det_reg) : SOLVE_W'(det_reg);
        n_sh  = DIV_W'(n_mag) << FRAC_BITS;
        d_top = DIV_W'(d_mag) << QUO_W;
    end

    always_comb begin
        if (neg_reg) begin
            if (ovf_reg || q_reg > QUO_W'(32768)) begin
                quo_sat = FLOW_W'(16'sh8000);
            end else begin
                quo_sat = FLOW_W'(-$signed({1'b0, q_reg}));
            end
        end else begin
            if (ovf_reg || q_reg > QUO_W'(32767)) begin
                quo_sat = FLOW_W'(16'sh7fff);
            end else begin
                quo_sat = FLOW_W'(q_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= n_sh;
            ds_reg  <= d_top >> 1;
            q_reg   <= '0;
            neg_reg <= num[SOLVE_W-1] ^ det_reg[SOLVE_W-1];
            ovf_reg <= (n_sh >= d_top);
        end else if (cmd.div_step) begin
            ds_reg <= ds_reg >> 1;
            if (rem_reg >= ds_reg) begin
                rem_reg <= rem_reg - ds_reg;
                q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.div_fin) begin
            if (cmd.div_sel) begin
                v_reg <= quo_sat;
            end else begin
                u_reg <= quo_sat;
            end
        end
    end

    // ---------------- output register ----------------
    logic m_valid_reg;
    logic solv;

    assign solv         = (det_reg != '0);
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_flow_u        <= solv ? u_reg : '0;
            m_flow_v        <= solv ? v_reg : '0;
            m_solvable      <= solv;
            m_center_col    <= px_reg - COL_W'(BORDER);
            m_center_row    <= py_reg - ROW_W'(BORDER);
            m_last_of_frame <= plast_reg;
        end
    end

endmodule
